[src/wcp_pkg.sv]
// shared types and constants for the wav container parser
package wcp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_HDR  = 2'd1,
        ST_CUT_CHDR = 2'd2,
        ST_BAD_FMT  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        data_chunk_start;
        logic        fmt_seen;
        logic [31:0] rate_hz;
        logic [15:0] channels;
        logic [15:0] sample_bits;
        logic        done_res;
        logic [1:0]  status;
    } out_word_t;

endpackage

[src/wcp_parser.sv]
// parse state registers and per-byte next-state and result logic
module wcp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  wcp_pkg::in_word_t   word,
    output wcp_pkg::out_word_t  res
);

    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_CHDR  = 3'd1,
        PH_FMT   = 3'd2,
        PH_DATA  = 3'd3,
        PH_SKIP  = 3'd4,
        PH_DRAIN = 3'd5
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [4:0]       count_reg, count_next;
    logic [31:0]      id_reg, id_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      left_reg, left_next;
    logic             until_reg, until_next;
    logic [31:0]      rate_reg, rate_next;
    logic [15:0]      chan_reg, chan_next;
    logic [15:0]      bits_reg, bits_next;
    logic             fmt_reg, fmt_next;
    wcp_pkg::status_t err_reg, err_next;

    always_comb
    begin
        logic [7:0]       b;
        logic [3:0]       k;
        logic             more;
        logic             dvalid;
        logic             dstart;
        wcp_pkg::status_t st;

        b          = word.byte_in;
        k          = count_reg[3:0];
        more       = 1'b0;
        dvalid     = 1'b0;
        dstart     = 1'b0;
        st         = wcp_pkg::ST_OK;
        phase_next = phase_reg;
        count_next = count_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        until_next = until_reg;
        rate_next  = rate_reg;
        chan_next  = chan_reg;
        bits_next  = bits_reg;
        fmt_next   = fmt_reg;
        err_next   = err_reg;

        case (phase_reg)
            PH_HDR:
            begin
                id_next    = {b, id_reg[31:8]};
                count_next = count_reg + 5'd1;
                if (count_reg == 5'd3 && id_next != wcp_pkg::TAG_RIFF)
                begin
                    err_next   = wcp_pkg::ST_BAD_HDR;
                    phase_next = PH_DRAIN;
                    count_next = '0;
                end
                else if (count_reg == 5'd11)
                begin
                    count_next = '0;
                    if (id_next != wcp_pkg::TAG_WAVE)
                    begin
                        err_next   = wcp_pkg::ST_BAD_HDR;
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        phase_next = PH_CHDR;
                    end
                end
            end
            PH_CHDR:
            begin
                if (count_reg < 5'd4)
                    id_next = {b, id_reg[31:8]};
                else
                    len_next = {b, len_reg[31:8]};
                count_next = count_reg + 5'd1;
                if (count_reg >= 5'd7)
                begin
                    until_next = len_next[31];
                    left_next  = len_next[31] ? 32'd0 : len_next;
                    more       = len_next[31] || (len_next != 32'd0);
                    count_next = '0;
                    if (id_next == wcp_pkg::TAG_FMT)
                    begin
                        if (!len_next[31] && len_next < wcp_pkg::FMT_MIN_LEN)
                        begin
                            err_next   = wcp_pkg::ST_BAD_FMT;
                            phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            phase_next = PH_FMT;
                            id_next    = '0;
                            len_next   = '0;
                        end
                    end
                    else if (id_next == wcp_pkg::TAG_DATA)
                    begin
                        dstart     = 1'b1;
                        phase_next = more ? PH_DATA : PH_CHDR;
                    end
                    else
                    begin
                        phase_next = more ? PH_SKIP : PH_CHDR;
                    end
                end
            end
            PH_FMT:
            begin
                if (k == 4'd2)
                    id_next[7:0] = b;
                else if (k == 4'd3)
                    id_next[15:8] = b;
                else if (k >= 4'd4 && k <= 4'd7)
                    len_next = {b, len_reg[31:8]};
                else if (k == 4'd14)
                    id_next[23:16] = b;
                else if (k == 4'd15)
                    id_next[31:24] = b;
                count_next = {1'b0, k} + 5'd1;
                if (!until_reg)
                    left_next = left_reg - 32'd1;
                if (k == 4'd15)
                begin
                    rate_next  = len_next;
                    chan_next  = id_next[15:0];
                    bits_next  = id_next[31:16];
                    fmt_next   = 1'b1;
                    count_next = '0;
                    if (until_reg || left_next != 32'd0)
                        phase_next = PH_SKIP;
                    else
                        phase_next = PH_CHDR;
                end
            end
            PH_DATA, PH_SKIP:
            begin
                dvalid = (phase_reg == PH_DATA);
                if (!until_reg)
                begin
                    left_next = left_reg - 32'd1;
                    if (left_next == 32'd0)
                    begin
                        phase_next = PH_CHDR;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (word.last)
        begin
            if (err_next != wcp_pkg::ST_OK)
                st = err_next;
            else if (phase_next == PH_HDR)
                st = wcp_pkg::ST_BAD_HDR;
            else if (phase_next == PH_CHDR && count_next != 5'd0)
                st = wcp_pkg::ST_CUT_CHDR;
            else if (phase_next == PH_FMT)
                st = wcp_pkg::ST_BAD_FMT;
            else
                st = wcp_pkg::ST_OK;
        end

        res.data_byte        = dvalid ? b : 8'd0;
        res.data_valid       = dvalid;
        res.data_chunk_start = dstart;
        res.fmt_seen         = fmt_next;
        res.rate_hz          = rate_next;
        res.channels         = chan_next;
        res.sample_bits      = bits_next;
        res.done_res         = word.last;
        res.status           = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            count_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            until_reg <= 1'b0;
            rate_reg  <= '0;
            chan_reg  <= '0;
            bits_reg  <= '0;
            fmt_reg   <= 1'b0;
            err_reg   <= wcp_pkg::ST_OK;
        end
        else if (accept)
        begin
            if (word.last)
            begin
                phase_reg <= PH_HDR;
                count_reg <= '0;
                id_reg    <= '0;
                len_reg   <= '0;
                left_reg  <= '0;
                until_reg <= 1'b0;
                rate_reg  <= '0;
                chan_reg  <= '0;
                bits_reg  <= '0;
                fmt_reg   <= 1'b0;
                err_reg   <= wcp_pkg::ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                id_reg    <= id_next;
                len_reg   <= len_next;
                left_reg  <= left_next;
                until_reg <= until_next;
                rate_reg  <= rate_next;
                chan_reg  <= chan_next;
                bits_reg  <= bits_next;
                fmt_reg   <= fmt_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

[src/wcp_out_buf.sv]
// result register with one skid entry
module wcp_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wcp_pkg::out_word_t  push_word,
    output logic                full,
    output logic                valid,
    input  logic                stall,
    output wcp_pkg::out_word_t  word
);

    logic               main_valid_reg;
    logic               skid_valid_reg;
    wcp_pkg::out_word_t main_reg;
    wcp_pkg::out_word_t skid_reg;
    logic               pop;

    assign pop   = main_valid_reg && !stall;
    assign valid = main_valid_reg;
    assign word  = main_reg;
    assign full  = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= push_word;
        end
        else if (push)
        begin
            skid_reg <= push_word;
        end
    end

endmodule

[src/wav_container_parser.sv]
// top level of the wav container parser
//
// usage:
//   the byte channel (byte_valid, byte_stall, byte_word) takes one file byte
//   per word together with a last flag on the final byte of the file
//   the result channel (res_valid, res_stall, res_word) gives exactly one
//   result word per byte word: payload byte and flags, the captured format
//   and, on the final byte, the parse status
//   throughput is one byte per cycle while byte_stall is low; each result
//   is registered in the output buffer after the combinational parse logic
//   a two-entry output buffer lets a new byte be taken while a result waits;
//   byte_stall rises only once both entries hold results and the receiver
//   keeps res_stall high, and falls the cycle after one is taken
//   reset clears the parse state to the file header phase and empties the
//   output buffer; after each final byte the parser rearms for a new file
//   with the captured format cleared
module wav_container_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  wcp_pkg::in_word_t   byte_word,
    output logic                res_valid,
    input  logic                res_stall,
    output wcp_pkg::out_word_t  res_word
);

    logic               accept;
    logic               buf_full;
    wcp_pkg::out_word_t parse_res;

    assign byte_stall = buf_full;
    assign accept     = byte_valid && !buf_full;

    wcp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (byte_word),
        .res    (parse_res)
    );

    wcp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (parse_res),
        .full      (buf_full),
        .valid     (res_valid),
        .stall     (res_stall),
        .word      (res_word)
    );

endmodule
